FILE: src/alvd_pkg.sv
// Shared constants, types and codes of the adaptive local variance denoiser.
`timescale 1ns / 1ps
`default_nettype none
package alvd_pkg;

  localparam int MAX_LINE_WIDTH = 2048;
  localparam int MAX_WINDOW_W   = 7;
  localparam int MAX_WINDOW_H   = 7;
  localparam int SAMPLE_BITS    = 8;
  localparam int MIN_WINDOW     = 3;
  localparam int NOISE_FRAC     = 4;

  localparam int SLOTS   = MAX_WINDOW_H - 1;
  localparam int COL_W   = $clog2(MAX_LINE_WIDTH);
  localparam int SLOT_W  = $clog2(SLOTS);
  localparam int WR_W    = $clog2(MAX_WINDOW_H);
  localparam int WC_W    = $clog2(MAX_WINDOW_W);
  localparam int DIM_W   = 12;
  localparam int ROW_W   = 12;
  localparam int WIN_W   = 3;
  localparam int NOISE_W = 34;
  localparam int PIX_W   = 16;
  localparam int OUT_W   = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 34;

  localparam int LAG_MAX = (MAX_WINDOW_H - 1 - MAX_WINDOW_H / 2) * MAX_LINE_WIDTH
                         + (MAX_WINDOW_W - 1 - MAX_WINDOW_W / 2);
  localparam int PEND_W  = $clog2(LAG_MAX + 2);

  localparam int N_W    = $clog2(MAX_WINDOW_W * MAX_WINDOW_H + 1);
  localparam int S_W    = SAMPLE_BITS + N_W;
  localparam int Q_W    = 2 * SAMPLE_BITS + N_W;
  localparam int NQ_W   = Q_W + N_W;
  localparam int NN_W   = 2 * N_W;
  localparam int THR_W  = NOISE_W + NN_W;
  localparam int DEN_W  = NQ_W + NOISE_FRAC;
  localparam int NZN_W  = NOISE_W + N_W;
  localparam int NUM_W  = NZN_W + S_W;
  localparam int DCNT_W = $clog2(NUM_W + 1);

  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_FLUSH = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FRAME_WIDTH,
    CFG_FRAME_HEIGHT,
    CFG_WINDOW_WIDTH,
    CFG_WINDOW_HEIGHT,
    CFG_NOISE_VARIANCE
  } cfg_index_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_READ,
    ST_UPDATE,
    ST_SUM,
    ST_MUL,
    ST_CMP,
    ST_NUM,
    ST_DIV,
    ST_FIX,
    ST_OUT
  } state_t;

endpackage
`default_nettype wire

FILE: src/alvd_if.sv
// Valid/ready channel interfaces for pixel input, result output and configuration.
`timescale 1ns / 1ps
`default_nettype none
interface alvd_in_if import alvd_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             operation;
  logic [PIX_W-1:0] pixel_value;
  logic             start_of_frame;
  modport source (output valid, operation, pixel_value, start_of_frame, input ready);
  modport sink   (input valid, operation, pixel_value, start_of_frame, output ready);
endinterface

interface alvd_out_if import alvd_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [OUT_W-1:0] pixel_out;
  logic             last_of_frame;
  modport source (output valid, pixel_out, last_of_frame, input ready);
  modport sink   (input valid, pixel_out, last_of_frame, output ready);
endinterface

interface alvd_cfg_if import alvd_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

FILE: src/adaptive_local_variance_denoise.sv
// Top level: line-buffered local statistics denoiser with iterative divider.
//
// Channels: in_ch carries one item per handshake (a pixel, or a flush that
// pushes out the oldest pending pixel); out_ch returns zero or one result item
// per input item in raster order; cfg_ch writes the five registers by index.
// A configuration write restarts the frame.
// Sequencing: the sequencer takes one item at a time. A filtered result
// passes through column accumulation over the window and a 54-step restoring
// divider; a pixel with no result or with a pass-through result skips both.
// The line store is one RAM read per item, written back for pixels only,
// one column of all stored rows per entry.
// Results sit in an output register, so a new item is accepted while a result
// waits; if the receiver stalls, the next result waits in its last step and
// in_ch.ready stays low until the output register frees.
// Reset: synchronous, active low; registers return to their defaults and the
// frame position and pending count clear. Line store and window contents are
// left as they are and are always written before use.
`timescale 1ns / 1ps
`default_nettype none
module adaptive_local_variance_denoise
  import alvd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  alvd_in_if.sink    in_ch,
  alvd_out_if.source out_ch,
  alvd_cfg_if.sink   cfg_ch
);

  localparam int RAM_W = SLOTS * SAMPLE_BITS;

  state_t state_r, state_nxt;

  logic [DIM_W-1:0]   frame_width_r, frame_height_r;
  logic [WIN_W-1:0]   window_width_r, window_height_r;
  logic [NOISE_W-1:0] noise_r;

  logic [COL_W:0]   we_eff;
  logic [ROW_W-1:0] he_eff;
  logic [WIN_W-1:0] ww, wh, dr, dc;
  logic [PEND_W-1:0] lag;
  logic [N_W-1:0]   n;

  logic [COL_W-1:0]  col_r, out_col_r;
  logic [ROW_W-1:0]  row_r, out_row_r;
  logic [SLOT_W-1:0] row_slot_r, out_slot_r;
  logic [PEND_W-1:0] pending_r, pend_inc;

  logic                   op_r;
  logic [SAMPLE_BITS-1:0] x_r;
  logic [SAMPLE_BITS-1:0] win_r [MAX_WINDOW_H][MAX_WINDOW_W];
  logic [SAMPLE_BITS-1:0] win_col [MAX_WINDOW_H];
  logic [SAMPLE_BITS-1:0] slot_a [SLOTS];
  logic [SAMPLE_BITS-1:0] slot_b [SLOTS];
  logic [RAM_W-1:0]       ram_rd_a, ram_rd_b, ram_wdata;
  logic                   ram_we;

  logic [WC_W-1:0]  j_r;
  logic [S_W-1:0]   s_r, col_sum;
  logic [Q_W-1:0]   q_r, col_sq;
  logic [NQ_W-1:0]  nq_r, ss_r, d_r;
  logic [S_W-1:0]   nx_r, a_r;
  logic [NN_W-1:0]  nn_r;
  logic [NZN_W-1:0] nzn_r;
  logic [THR_W-1:0] thr_r;
  logic [SAMPLE_BITS-1:0] cx_r;
  logic             ge_r, mean_r;

  logic [NUM_W-1:0]  quo_r;
  logic [DEN_W-1:0]  rem_r, den_r, rem_nxt;
  logic [DEN_W:0]    trial;
  logic              q_bit;
  logic [DCNT_W-1:0] cnt_r;

  logic [OUT_W-1:0] val_r, k;
  logic             last_r, last_now;
  logic             out_valid_r;
  logic [OUT_W-1:0] out_pixel_r;
  logic             out_last_r;

  logic in_fire, cfg_fire, cfg_hit, out_free, emit, filt, restart;

  assign in_fire  = in_ch.valid && in_ch.ready;
  assign cfg_fire = cfg_ch.valid && cfg_ch.ready;
  assign out_free = !out_valid_r || out_ch.ready;

  assign in_ch.ready          = (state_r == ST_IDLE);
  assign cfg_ch.ready         = 1'b1;
  assign out_ch.valid         = out_valid_r;
  assign out_ch.pixel_out     = out_pixel_r;
  assign out_ch.last_of_frame = out_last_r;

  always_comb begin
    if (frame_width_r == '0) begin
      we_eff = (COL_W+1)'(1);
    end else if (int'(frame_width_r) > MAX_LINE_WIDTH) begin
      we_eff = (COL_W+1)'(MAX_LINE_WIDTH);
    end else begin
      we_eff = (COL_W+1)'(frame_width_r);
    end
    he_eff = (frame_height_r == '0) ? ROW_W'(1) : frame_height_r;
    if (int'(window_width_r) < MIN_WINDOW) begin
      ww = WIN_W'(MIN_WINDOW);
    end else if (int'(window_width_r) > MAX_WINDOW_W) begin
      ww = WIN_W'(MAX_WINDOW_W);
    end else begin
      ww = window_width_r;
    end
    if (int'(window_height_r) < MIN_WINDOW) begin
      wh = WIN_W'(MIN_WINDOW);
    end else if (int'(window_height_r) > MAX_WINDOW_H) begin
      wh = WIN_W'(MAX_WINDOW_H);
    end else begin
      wh = window_height_r;
    end
    dr  = wh - WIN_W'(1) - (wh >> 1);
    dc  = ww - WIN_W'(1) - (ww >> 1);
    lag = PEND_W'(dr) * PEND_W'(we_eff) + PEND_W'(dc);
    n   = N_W'(ww) * N_W'(wh);
  end

  always_comb begin
    cfg_hit = 1'b0;
    if (cfg_fire) begin
      case (cfg_index_t'(cfg_ch.index))
        CFG_FRAME_WIDTH, CFG_FRAME_HEIGHT, CFG_WINDOW_WIDTH,
        CFG_WINDOW_HEIGHT, CFG_NOISE_VARIANCE: cfg_hit = 1'b1;
        default: cfg_hit = 1'b0;
      endcase
    end
  end

  always_comb begin
    for (int s = 0; s < SLOTS; s++) begin
      slot_a[s] = ram_rd_a[s*SAMPLE_BITS +: SAMPLE_BITS];
      slot_b[s] = ram_rd_b[s*SAMPLE_BITS +: SAMPLE_BITS];
      ram_wdata[s*SAMPLE_BITS +: SAMPLE_BITS] =
        (SLOT_W'(s) == row_slot_r) ? x_r : slot_a[s];
    end
  end

  assign ram_we = (state_r == ST_UPDATE) && (op_r == OP_PIXEL);

  alvd_ram #(
    .WIDTH (RAM_W),
    .DEPTH (MAX_LINE_WIDTH)
  ) u_line_ram (
    .clk       (clk),
    .wr_en     (ram_we),
    .wr_addr   (col_r),
    .wr_data   (ram_wdata),
    .rd_en     (state_r == ST_READ),
    .rd_addr_a (col_r),
    .rd_data_a (ram_rd_a),
    .rd_addr_b (out_col_r),
    .rd_data_b (ram_rd_b)
  );

  always_comb begin
    logic [SLOT_W:0] back_v, sidx_v;
    for (int i = 0; i < MAX_WINDOW_H; i++) begin
      back_v = (SLOT_W+1)'(wh) - (SLOT_W+1)'(1) - (SLOT_W+1)'(i);
      sidx_v = (SLOT_W+1)'(row_slot_r) + (SLOT_W+1)'(SLOTS) - back_v;
      if (sidx_v >= (SLOT_W+1)'(SLOTS)) begin
        sidx_v = sidx_v - (SLOT_W+1)'(SLOTS);
      end
      win_col[i] = win_r[i][MAX_WINDOW_W-1];
      if (i == int'(wh) - 1) begin
        win_col[i] = x_r;
      end else if (i < int'(wh) - 1) begin
        win_col[i] = (row_r >= ROW_W'(back_v)) ? slot_a[sidx_v[SLOT_W-1:0]] : '0;
      end
    end
  end

  always_comb begin
    col_sum = '0;
    col_sq  = '0;
    for (int i = 0; i < MAX_WINDOW_H; i++) begin
      if (i < int'(wh)) begin
        col_sum = col_sum + S_W'(win_r[i][j_r]);
        col_sq  = col_sq + Q_W'(win_r[i][j_r]) * Q_W'(win_r[i][j_r]);
      end
    end
  end

  assign pend_inc = pending_r + PEND_W'(1);
  assign emit     = (op_r == OP_FLUSH) || (pend_inc > lag);
  assign filt     = (op_r == OP_PIXEL)
                 && (out_row_r >= ROW_W'(wh >> 1))
                 && (({1'b0, out_row_r} + (ROW_W+1)'(dr)) < {1'b0, he_eff})
                 && (out_col_r >= COL_W'(ww >> 1))
                 && (({1'b0, out_col_r} + (COL_W+1)'(dc)) < we_eff);
  assign last_now = (out_row_r == he_eff - ROW_W'(1))
                 && ({1'b0, out_col_r} == we_eff - (COL_W+1)'(1));
  assign restart  = in_fire && (in_ch.operation == OP_PIXEL)
                 && (in_ch.start_of_frame || row_r >= he_eff);

  assign trial   = {rem_r, quo_r[NUM_W-1]};
  assign q_bit   = (trial >= {1'b0, den_r});
  assign rem_nxt = q_bit ? DEN_W'(trial - {1'b0, den_r}) : trial[DEN_W-1:0];
  assign k       = quo_r[OUT_W-1:0];

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_fire && (in_ch.operation == OP_PIXEL || pending_r != '0)) begin
          state_nxt = ST_READ;
        end
      end
      ST_READ:   state_nxt = ST_UPDATE;
      ST_UPDATE: begin
        if (!emit) begin
          state_nxt = ST_IDLE;
        end else if (filt) begin
          state_nxt = ST_SUM;
        end else begin
          state_nxt = ST_OUT;
        end
      end
      ST_SUM: begin
        if (j_r == WC_W'(MAX_WINDOW_W - 1)) begin
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: state_nxt = ST_CMP;
      ST_CMP: state_nxt = ST_NUM;
      ST_NUM: state_nxt = ST_DIV;
      ST_DIV: begin
        if (cnt_r == DCNT_W'(1)) begin
          state_nxt = ST_FIX;
        end
      end
      ST_FIX: state_nxt = ST_OUT;
      ST_OUT: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r   <= DIM_W'(640);
      frame_height_r  <= DIM_W'(480);
      window_width_r  <= WIN_W'(5);
      window_height_r <= WIN_W'(5);
      noise_r         <= '0;
      col_r           <= '0;
      row_r           <= '0;
      row_slot_r      <= '0;
      out_col_r       <= '0;
      out_row_r       <= '0;
      out_slot_r      <= '0;
      pending_r       <= '0;
      out_valid_r     <= 1'b0;
    end else begin
      if (restart) begin
        col_r      <= '0;
        row_r      <= '0;
        row_slot_r <= '0;
        out_col_r  <= '0;
        out_row_r  <= '0;
        out_slot_r <= '0;
        pending_r  <= '0;
      end
      if (state_r == ST_UPDATE) begin
        if (op_r == OP_PIXEL) begin
          pending_r <= emit ? pending_r : pend_inc;
          if ({1'b0, col_r} + (COL_W+1)'(1) >= we_eff) begin
            col_r      <= '0;
            row_r      <= row_r + ROW_W'(1);
            row_slot_r <= (row_slot_r == SLOT_W'(SLOTS - 1)) ? '0 : row_slot_r + SLOT_W'(1);
          end else begin
            col_r <= col_r + COL_W'(1);
          end
        end else begin
          pending_r <= pending_r - PEND_W'(1);
        end
        if (emit) begin
          if ({1'b0, out_col_r} + (COL_W+1)'(1) >= we_eff) begin
            out_col_r  <= '0;
            out_row_r  <= out_row_r + ROW_W'(1);
            out_slot_r <= (out_slot_r == SLOT_W'(SLOTS - 1)) ? '0 : out_slot_r + SLOT_W'(1);
          end else begin
            out_col_r <= out_col_r + COL_W'(1);
          end
        end
      end
      if (state_r == ST_OUT && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_fire) begin
        case (cfg_index_t'(cfg_ch.index))
          CFG_FRAME_WIDTH:    frame_width_r   <= cfg_ch.data[DIM_W-1:0];
          CFG_FRAME_HEIGHT:   frame_height_r  <= cfg_ch.data[DIM_W-1:0];
          CFG_WINDOW_WIDTH:   window_width_r  <= cfg_ch.data[WIN_W-1:0];
          CFG_WINDOW_HEIGHT:  window_height_r <= cfg_ch.data[WIN_W-1:0];
          CFG_NOISE_VARIANCE: noise_r         <= cfg_ch.data[NOISE_W-1:0];
          default: ;
        endcase
      end
      if (cfg_hit) begin
        col_r      <= '0;
        row_r      <= '0;
        row_slot_r <= '0;
        out_col_r  <= '0;
        out_row_r  <= '0;
        out_slot_r <= '0;
        pending_r  <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      op_r <= in_ch.operation;
      x_r  <= in_ch.pixel_value[SAMPLE_BITS-1:0];
    end
    case (state_r)
      ST_UPDATE: begin
        if (op_r == OP_PIXEL) begin
          for (int i = 0; i < MAX_WINDOW_H; i++) begin
            for (int j = 0; j < MAX_WINDOW_W - 1; j++) begin
              win_r[i][j] <= win_r[i][j+1];
            end
            win_r[i][MAX_WINDOW_W-1] <= win_col[i];
          end
        end
        val_r  <= OUT_W'(slot_b[out_slot_r]);
        last_r <= last_now;
        s_r    <= '0;
        q_r    <= '0;
        j_r    <= '0;
      end
      ST_SUM: begin
        if (j_r >= WC_W'(MAX_WINDOW_W) - WC_W'(ww)) begin
          s_r <= s_r + col_sum;
          q_r <= q_r + col_sq;
        end
        j_r <= j_r + WC_W'(1);
      end
      ST_MUL: begin
        cx_r  <= win_r[WR_W'(wh >> 1)][WC_W'(MAX_WINDOW_W - 1) - WC_W'(dc)];
        nq_r  <= NQ_W'(n) * NQ_W'(q_r);
        ss_r  <= NQ_W'(s_r) * NQ_W'(s_r);
        nx_r  <= S_W'(n) * S_W'(win_r[WR_W'(wh >> 1)][WC_W'(MAX_WINDOW_W - 1) - WC_W'(dc)]);
        nn_r  <= NN_W'(n) * NN_W'(n);
        nzn_r <= NZN_W'(noise_r) * NZN_W'(n);
      end
      ST_CMP: begin
        d_r   <= nq_r - ss_r;
        thr_r <= THR_W'(noise_r) * THR_W'(nn_r);
        ge_r  <= (nx_r >= s_r);
        a_r   <= (nx_r >= s_r) ? nx_r - s_r : s_r - nx_r;
      end
      ST_NUM: begin
        rem_r <= '0;
        cnt_r <= DCNT_W'(NUM_W);
        if ((THR_W'(d_r) << NOISE_FRAC) <= thr_r) begin
          mean_r <= 1'b1;
          quo_r  <= NUM_W'(s_r);
          den_r  <= DEN_W'(n);
        end else begin
          mean_r <= 1'b0;
          quo_r  <= NUM_W'(nzn_r) * NUM_W'(a_r);
          den_r  <= DEN_W'(d_r) << NOISE_FRAC;
        end
      end
      ST_DIV: begin
        rem_r <= rem_nxt;
        quo_r <= {quo_r[NUM_W-2:0], q_bit};
        cnt_r <= cnt_r - DCNT_W'(1);
      end
      ST_FIX: begin
        if (mean_r) begin
          val_r <= k;
        end else if (ge_r) begin
          val_r <= OUT_W'(cx_r) - k - OUT_W'(rem_r != '0);
        end else begin
          val_r <= OUT_W'(cx_r) + k;
        end
      end
      default: ;
    endcase
    if (state_r == ST_OUT && out_free) begin
      out_pixel_r <= val_r;
      out_last_r  <= last_r;
    end
  end

`ifndef SYNTHESIS
  a_pend_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_IDLE |-> pending_r <= lag)
    else $error("pending count exceeds window lag");
  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_IDLE |-> ({1'b0, col_r} < we_eff) && ({1'b0, out_col_r} < we_eff))
    else $error("column position outside line");
  a_div_den: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_DIV |-> den_r != '0)
    else $error("divider loaded with zero denominator");
  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == ST_OUT)
    else $error("result raised outside output step");
`endif

endmodule
`default_nettype wire

FILE: src/alvd_ram.sv
// Generic single-write, dual-read synchronous RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module alvd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr_a,
  output logic [WIDTH-1:0] rd_data_a,
  input  logic [AW-1:0]    rd_addr_b,
  output logic [WIDTH-1:0] rd_data_b
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_a <= mem_r[rd_addr_a];
      rd_data_b <= mem_r[rd_addr_b];
    end
  end

endmodule
`default_nettype wire

FILE: test/adaptive_local_variance_denoise_tb.sv
// Self-checking testbench for the adaptive local variance denoiser.
`timescale 1ns / 1ps
`default_nettype none
module adaptive_local_variance_denoise_tb;
  import alvd_pkg::*;

  typedef struct packed {
    logic             op;
    logic [PIX_W-1:0] pix;
    logic             sof;
  } pixel_item_t;

  typedef struct packed {
    logic [OUT_W-1:0] pix;
    logic             last;
  } filtered_px_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  alvd_in_if  in_ch ();
  alvd_out_if out_ch ();
  alvd_cfg_if cfg_ch ();

  adaptive_local_variance_denoise DUT (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch.sink),
    .out_ch(out_ch.source),
    .cfg_ch(cfg_ch.sink)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  pixel_item_t  pixel_queue[$];
  filtered_px_t expected_px[$];
  int  errors = 0;
  bit  cfg_req = 1'b0;
  bit  cfg_done = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_req_idx;
  logic [CFG_DATA_W-1:0] cfg_req_data;

  // shadow state of the filter
  int unsigned fw, fh, wwin, hwin;
  logic [NOISE_W-1:0] noise;
  logic [15:0] lines[SLOTS*MAX_LINE_WIDTH];
  logic [15:0] win[MAX_WINDOW_H][MAX_WINDOW_W];
  int unsigned col_pos, row_pos, pend;

  function automatic int unsigned clip_win(int unsigned v, int unsigned hi);
    return v < 3 ? 3 : (v > hi ? hi : v);
  endfunction

  function automatic int unsigned line_px(int unsigned r, int unsigned c);
    return lines[(r % SLOTS) * MAX_LINE_WIDTH + (c % MAX_LINE_WIDTH)];
  endfunction

  function automatic int unsigned lee_window(int unsigned ww, int unsigned wh);
    logic [127:0] n, s, q, x, d, nx, a, num, k, rem;
    n = ww * wh;
    s = 0;
    q = 0;
    for (int i = 0; i < wh; i++)
      for (int j = MAX_WINDOW_W - ww; j < MAX_WINDOW_W; j++) begin
        s += win[i][j];
        q += win[i][j] * win[i][j];
      end
    x = win[wh/2][MAX_WINDOW_W - 1 - (ww - 1 - ww/2)];
    d = n * q - s * s;
    if (16 * d <= noise * n * n) return s / n;
    nx = n * x;
    a = nx >= s ? nx - s : s - nx;
    num = noise * n * a;
    k = num / (16 * d);
    rem = num % (16 * d);
    if (nx >= s) return x - k - (rem != 0 ? 1 : 0);
    return x + k;
  endfunction

  function automatic void apply_config(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] v);
    case (idx)
      CFG_FRAME_WIDTH:    fw = v[11:0];
      CFG_FRAME_HEIGHT:   fh = v[11:0];
      CFG_WINDOW_WIDTH:   wwin = v[2:0];
      CFG_WINDOW_HEIGHT:  hwin = v[2:0];
      CFG_NOISE_VARIANCE: noise = v[NOISE_W-1:0];
      default: return;
    endcase
    col_pos = 0;
    row_pos = 0;
    pend = 0;
  endfunction

  function automatic void predict_pixel(pixel_item_t it);
    int unsigned we, he, ww, wh, dr, dc, lag, qidx, ro, co, val, r, c, x;
    bit filt;
    filtered_px_t e;
    we = fw == 0 ? 1 : (fw > MAX_LINE_WIDTH ? MAX_LINE_WIDTH : fw);
    he = fh == 0 ? 1 : fh;
    ww = clip_win(wwin, MAX_WINDOW_W);
    wh = clip_win(hwin, MAX_WINDOW_H);
    dr = wh - 1 - wh/2;
    dc = ww - 1 - ww/2;
    lag = dr * we + dc;
    filt = 1'b0;
    if (it.op == OP_FLUSH) begin
      if (pend == 0) return;
      qidx = row_pos * we + col_pos - pend;
    end else begin
      x = it.pix[SAMPLE_BITS-1:0];
      if (it.sof || row_pos >= he) begin
        row_pos = 0;
        col_pos = 0;
        pend = 0;
      end
      r = row_pos;
      c = col_pos;
      for (int i = 0; i < MAX_WINDOW_H; i++)
        for (int j = 0; j + 1 < MAX_WINDOW_W; j++) win[i][j] = win[i][j+1];
      for (int i = 0; i + 1 < wh; i++)
        win[i][MAX_WINDOW_W-1] = r >= wh - 1 - i ? line_px(r - (wh - 1 - i), c) : 0;
      win[wh-1][MAX_WINDOW_W-1] = x;
      lines[(r % SLOTS) * MAX_LINE_WIDTH + c] = x;
      pend++;
      col_pos++;
      if (col_pos >= we) begin
        col_pos = 0;
        row_pos++;
      end
      if (pend <= lag) return;
      qidx = r * we + c + 1 - pend;
      filt = 1'b1;
    end
    ro = qidx / we;
    co = qidx % we;
    if (filt && ro >= wh/2 && ro + dr < he && co >= ww/2 && co + dc < we)
      val = lee_window(ww, wh);
    else
      val = line_px(ro, co);
    pend--;
    e.pix = val[15:0];
    e.last = qidx == we * he - 1;
    expected_px.push_back(e);
  endfunction

  // driver
  int unsigned in_gap = 0;
  bit hold_in = 1'b0;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      in_ch.operation <= OP_PIXEL;
      in_ch.pixel_value <= '0;
      in_ch.start_of_frame <= 1'b0;
    end else if (in_ch.valid && !in_ch.ready) begin
    end else begin
      if (in_ch.valid) predict_pixel({in_ch.operation, in_ch.pixel_value, in_ch.start_of_frame});
      if (in_gap > 0 || hold_in || pixel_queue.size() == 0) begin
        in_ch.valid <= 1'b0;
        if (in_gap > 0) in_gap--;
      end else begin
        pixel_item_t it;
        it = pixel_queue.pop_front();
        in_ch.valid <= 1'b1;
        in_ch.operation <= it.op;
        in_ch.pixel_value <= it.pix;
        in_ch.start_of_frame <= it.sof;
        in_gap = $urandom_range(0, 3) == 0 ? $urandom_range(0, 10) : 0;
      end
    end
  end

  // configuration writer
  always @(posedge clk) begin
    if (!rst_n) begin
      cfg_ch.valid <= 1'b0;
      cfg_ch.index <= '0;
      cfg_ch.data <= '0;
    end else if (cfg_ch.valid) begin
      if (cfg_ch.ready) begin
        apply_config(cfg_ch.index, cfg_ch.data);
        cfg_ch.valid <= 1'b0;
        cfg_done <= 1'b1;
      end
    end else if (cfg_req && !cfg_done) begin
      cfg_ch.valid <= 1'b1;
      cfg_ch.index <= cfg_req_idx;
      cfg_ch.data <= cfg_req_data;
    end else if (!cfg_req) begin
      cfg_done <= 1'b0;
    end
  end

  // monitor
  int unsigned out_gap = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_px.size() == 0) begin
          $error("unexpected item pixel_out=%0d", out_ch.pixel_out);
          errors++;
        end else begin
          filtered_px_t e;
          e = expected_px.pop_front();
          if (out_ch.pixel_out !== e.pix) begin
            $error("pixel_out expected %0d actual %0d", e.pix, out_ch.pixel_out);
            errors++;
          end
          if (out_ch.last_of_frame !== e.last) begin
            $error("last_of_frame expected %0d actual %0d", e.last, out_ch.last_of_frame);
            errors++;
          end
        end
        out_gap = $urandom_range(0, 3) == 0 ? $urandom_range(0, 10) : 0;
      end
      if (out_gap > 0) begin
        out_ch.ready <= 1'b0;
        out_gap--;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  task automatic wait_drained();
    while (pixel_queue.size() != 0 || in_ch.valid || expected_px.size() != 0)
      @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] v);
    cfg_req_idx = idx;
    cfg_req_data = v;
    cfg_req = 1'b1;
    @(posedge clk);
    while (!cfg_done) @(posedge clk);
    cfg_req = 1'b0;
    @(posedge clk);
    while (cfg_done) @(posedge clk);
  endtask

  task automatic push_px(logic op, logic [15:0] v, logic sof);
    pixel_item_t it;
    it.op = op;
    it.pix = v;
    it.sof = sof;
    pixel_queue.push_back(it);
  endtask

  task automatic setup(int unsigned w, int unsigned h, int unsigned ww, int unsigned wh,
                       logic [NOISE_W-1:0] nv);
    wait_drained();
    write_reg(CFG_FRAME_WIDTH, w);
    write_reg(CFG_FRAME_HEIGHT, h);
    write_reg(CFG_WINDOW_WIDTH, ww);
    write_reg(CFG_WINDOW_HEIGHT, wh);
    write_reg(CFG_NOISE_VARIANCE, nv);
  endtask

  // one frame: mostly smooth content with noise, sometimes full range
  task automatic push_frame(int unsigned w, int unsigned h, int unsigned flushes);
    int unsigned base;
    base = $urandom_range(0, 255);
    for (int unsigned i = 0; i < w * h; i++) begin
      logic [15:0] v;
      v = $urandom();
      if ($urandom_range(0, 2) != 0) v[7:0] = base + $urandom_range(0, 40);
      push_px(OP_PIXEL, v, i == 0 ? 1'b1 : ($urandom_range(0, 40) == 0));
      if ($urandom_range(0, 60) == 0) push_px(OP_FLUSH, $urandom(), $urandom_range(0, 1));
    end
    for (int unsigned i = 0; i < flushes; i++) push_px(OP_FLUSH, $urandom(), $urandom_range(0, 1));
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.operation = OP_PIXEL;
    in_ch.pixel_value = '0;
    in_ch.start_of_frame = 1'b0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data = '0;
    fw = 640; fh = 480; wwin = 5; hwin = 5; noise = '0;
    col_pos = 0; row_pos = 0; pend = 0;
    for (int i = 0; i < MAX_WINDOW_H; i++)
      for (int j = 0; j < MAX_WINDOW_W; j++) win[i][j] = '0;
    for (int i = 0; i < SLOTS*MAX_LINE_WIDTH; i++) lines[i] = '0;
    hold_in = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: flush on empty, extremes, small frame, window and noise extremes
    setup(8, 8, 3, 3, '0);
    push_px(OP_FLUSH, 16'hFFFF, 1'b1);
    push_px(OP_PIXEL, 16'hFFFF, 1'b1);
    push_px(OP_PIXEL, 16'h0000, 1'b0);
    push_px(OP_PIXEL, 16'hFF00, 1'b0);
    push_px(OP_PIXEL, 16'h00FF, 1'b0);
    push_px(OP_FLUSH, 16'h1234, 1'b0);
    push_px(OP_PIXEL, 16'h5A5A, 1'b1);
    for (int i = 0; i < 18; i++) push_px(OP_PIXEL, (i % 2) ? 16'hFFFF : 16'h0000, 1'b0);
    push_px(OP_FLUSH, 16'h0, 1'b0);
    setup(0, 0, 0, 0, {NOISE_W{1'b1}});
    push_px(OP_PIXEL, 16'hAAAA, 1'b1);
    push_px(OP_PIXEL, 16'h5555, 1'b0);
    setup(8, 8, 7, 7, 34'h10);
    push_frame(8, 8, 30);
    // hold the sender until the block drains
    while (pixel_queue.size() != 0) @(posedge clk);
    hold_in = 1'b1;
    while (expected_px.size() != 0 || in_ch.valid) @(posedge clk);
    hold_in = 1'b0;

    // random phases over several settings
    for (int ph = 0; ph < 6; ph++) begin
      int unsigned w, h;
      w = $urandom_range(8, 14);
      h = $urandom_range(8, 10);
      case (ph)
        0: setup(w, h, 3, 7, 34'h0);
        1: setup(w, h, 7, 3, {NOISE_W{1'b1}});
        2: setup(w, h, 5, 5, $urandom_range(16, 4000));
        3: setup(4095, h, 4, 6, 34'h200);
        4: setup(w, 4095, 6, 4, $urandom_range(0, 1000));
        default: setup(w, h, $urandom_range(0, 7), $urandom_range(0, 7),
                       {$urandom(), $urandom()});
      endcase
      if (ph == 3) begin
        for (int i = 0; i < 60; i++) push_px(OP_PIXEL, $urandom(), i == 0);
        for (int i = 0; i < 40; i++) push_px(OP_FLUSH, $urandom(), 1'b0);
      end else begin
        push_frame(w, ph == 4 ? 6 : h, 15);
      end
    end
    wait_drained();
    if (errors == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

  initial begin
    #50ms;
    $display("TB_ERROR");
    $finish;
  end

endmodule
`default_nettype wire
